FILE: rtl/core/tsnb_pkg.sv
// ----------------------------------------------------------------------------
// tsnb_pkg
// Shared widths, stage counts and item types for the tangent-space normal bake.
// ----------------------------------------------------------------------------
package tsnb_pkg;

	localparam int COMP_W     = 16;                 // input component, Q2.14
	localparam int OUT_W      = 16;                 // unit component, Q1.14
	localparam int MAG_W      = 31;                 // magnitude after range shift
	localparam int SUM_W      = 64;                 // sum of three squares
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int UNIT_SH    = 14;                 // 1.0 in Q1.14
	localparam int QUO_W      = UNIT_SH + 1;        // quotient never exceeds 1.0
	localparam int NUM_W      = MAG_W + UNIT_SH + 1;
	localparam int PRE_LAT    = 5;                  // magnitude, shift search, shift, square, sum
	localparam int UNIT_LAT   = PRE_LAT + ROOT_STEPS + 1 + QUO_W + 1;
	localparam int CROSS_W    = 2 * COMP_W + 1;
	localparam int PROJ_W     = COMP_W + OUT_W + 2;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [OUT_W-1:0]  unit_t;

	typedef struct packed {
		comp_t normal_x;
		comp_t normal_y;
		comp_t normal_z;
		comp_t tangent_x;
		comp_t tangent_y;
		comp_t tangent_z;
		comp_t smooth_x;
		comp_t smooth_y;
		comp_t smooth_z;
	} vertex_t;

	typedef struct packed {
		unit_t color_x;
		unit_t color_y;
		unit_t color_z;
		logic  degenerate;
	} color_t;

	// carried alongside the square root
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  zero;
	} unit_side_t;

endpackage

FILE: rtl/core/tsnb_isqrt.sv
// ----------------------------------------------------------------------------
// tsnb_isqrt
// Pipelined floor square root, one result bit per stage, with a side payload.
// ----------------------------------------------------------------------------
module tsnb_isqrt
	import tsnb_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [ROOT_STEPS+1];
	logic [SUM_W-1:0]  rad_s  [ROOT_STEPS+1];
	logic [SUM_W-1:0]  res_s  [ROOT_STEPS+1];
	logic [SIDE_W-1:0] side_s [ROOT_STEPS+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = in_rad;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_step
		localparam int BIT_POS = SUM_W - 2 - 2 * j;
		logic [SUM_W-1:0] bitv;
		logic [SUM_W-1:0] trial;
		logic [SUM_W-1:0] rad_nx;
		logic [SUM_W-1:0] res_nx;

		always_comb begin
			bitv  = SUM_W'(1) << BIT_POS;
			trial = res_s[j] + bitv;
			if (rad_s[j] >= trial) begin
				rad_nx = rad_s[j] - trial;
				res_nx = (res_s[j] >> 1) + bitv;
			end else begin
				rad_nx = rad_s[j];
				res_nx = res_s[j] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j+1]  <= rad_nx;
				res_s[j+1]  <= res_nx;
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = vld_s[ROOT_STEPS];
	assign out_root  = ROOT_W'(res_s[ROOT_STEPS]);
	assign out_side  = side_s[ROOT_STEPS];

endmodule

FILE: rtl/core/tsnb_unitize.sv
// ----------------------------------------------------------------------------
// tsnb_unitize
// Normalizes a signed 3-vector to Q1.14: range shift, sum of squares,
// pipelined root, then one restoring quotient bit per stage per lane.
// ----------------------------------------------------------------------------
module tsnb_unitize
	import tsnb_pkg::*;
#(
	parameter int VW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [2:0][VW-1:0]    in_vec,
	output logic                  out_valid,
	output logic [2:0][OUT_W-1:0] out_vec,
	output logic                  out_zero
);

	localparam int SH_W   = $clog2(VW);
	localparam int SIDE_W = $bits(unit_side_t);

	// magnitudes
	logic                 vld_s1;
	logic [2:0][VW-1:0]   mag_s1;
	logic [2:0]           neg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= in_vec[i][VW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
				neg_s1[i] <= in_vec[i][VW-1];
			end
		end
	end

	// range shift search; OR of the magnitudes has the same top bit as the largest
	logic [VW-1:0]   any_mag;
	logic [SH_W-1:0] sh_nx;
	logic            vld_s2;
	logic [2:0][VW-1:0] mag_s2;
	logic [2:0]      neg_s2;
	logic            zero_s2;
	logic [SH_W-1:0] sh_s2;

	assign any_mag = mag_s1[0] | mag_s1[1] | mag_s1[2];

	if (VW > MAG_W) begin : g_shift
		always_comb begin
			sh_nx = '0;
			for (int k = MAG_W; k < VW; k++) begin
				if (any_mag[k]) begin
					sh_nx = SH_W'(k - MAG_W + 1);
				end
			end
		end
	end else begin : g_noshift
		assign sh_nx = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= (any_mag == '0);
			sh_s2   <= sh_nx;
		end
	end

	// apply shift
	logic                  vld_s3;
	logic [2:0][MAG_W-1:0] m_s3;
	logic [2:0]            neg_s3;
	logic                  zero_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				m_s3[i] <= MAG_W'(mag_s2[i] >> sh_s2);
			end
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// squares
	logic                    vld_s4;
	logic [2:0][2*MAG_W-1:0] sq_s4;
	unit_side_t              side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= (2*MAG_W)'(m_s3[i]) * (2*MAG_W)'(m_s3[i]);
			end
			side_s4.mag  <= m_s3;
			side_s4.neg  <= neg_s3;
			side_s4.zero <= zero_s3;
		end
	end

	// sum of squares
	logic             vld_s5;
	logic [SUM_W-1:0] sum_s5;
	unit_side_t       side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5  <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			side_s5 <= side_s4;
		end
	end

	// root
	logic              rt_valid;
	logic [ROOT_W-1:0] rt_root;
	logic [SIDE_W-1:0] rt_side_raw;
	unit_side_t        rt_side;

	tsnb_isqrt #(
		.SIDE_W(SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.in_rad   (sum_s5),
		.in_side  (side_s5),
		.out_valid(rt_valid),
		.out_root (rt_root),
		.out_side (rt_side_raw)
	);

	assign rt_side = unit_side_t'(rt_side_raw);

	// division: index 0 holds the rounded numerators
	logic                  vld_d  [QUO_W+1];
	logic [2:0][NUM_W-1:0] rem_d  [QUO_W+1];
	logic [2:0][QUO_W-1:0] quo_d  [QUO_W+1];
	logic [ROOT_W-1:0]     root_d [QUO_W+1];
	logic [2:0]            neg_d  [QUO_W+1];
	logic                  zero_d [QUO_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d[0] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= rt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_d[0][i] <= (NUM_W'(rt_side.mag[i]) << UNIT_SH) + NUM_W'(rt_root >> 1);
			end
			quo_d[0]  <= '0;
			root_d[0] <= rt_root;
			neg_d[0]  <= rt_side.neg;
			zero_d[0] <= rt_side.zero;
		end
	end

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		localparam int QBIT = QUO_W - 1 - j;
		logic [NUM_W-1:0]      dvs;
		logic [2:0][NUM_W-1:0] rem_nx;
		logic [2:0][QUO_W-1:0] quo_nx;

		always_comb begin
			dvs    = NUM_W'(root_d[j]) << QBIT;
			rem_nx = rem_d[j];
			quo_nx = quo_d[j];
			for (int i = 0; i < 3; i++) begin
				if (rem_d[j][i] >= dvs) begin
					rem_nx[i]       = rem_d[j][i] - dvs;
					quo_nx[i][QBIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[j+1] <= 1'b0;
			end else if (en) begin
				vld_d[j+1] <= vld_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[j+1]  <= rem_nx;
				quo_d[j+1]  <= quo_nx;
				root_d[j+1] <= root_d[j];
				neg_d[j+1]  <= neg_d[j];
				zero_d[j+1] <= zero_d[j];
			end
		end
	end

	// sign and zero forcing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_d[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (zero_d[QUO_W]) begin
					out_vec[i] <= '0;
				end else if (neg_d[QUO_W][i]) begin
					out_vec[i] <= ~OUT_W'(quo_d[QUO_W][i]) + 1'b1;
				end else begin
					out_vec[i] <= OUT_W'(quo_d[QUO_W][i]);
				end
			end
			out_zero <= zero_d[QUO_W];
		end
	end

endmodule

FILE: rtl/core/tsnb_project.sv
// ----------------------------------------------------------------------------
// tsnb_project
// Projects the smoothed normal onto the three unit axes: products, then sums.
// ----------------------------------------------------------------------------
module tsnb_project
	import tsnb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [2:0][OUT_W-1:0]  axis_t,
	input  logic [2:0][OUT_W-1:0]  axis_b,
	input  logic [2:0][OUT_W-1:0]  axis_n,
	input  logic [2:0][COMP_W-1:0] smooth,
	output logic                   out_valid,
	output logic [2:0][PROJ_W-1:0] proj
);

	localparam int PROD_W = OUT_W + COMP_W;

	logic [2:0][OUT_W-1:0] axes [3];
	logic                  vld_s1;
	logic signed [PROD_W-1:0] prod_s1 [3][3];

	assign axes[0] = axis_t;
	assign axes[1] = axis_b;
	assign axes[2] = axis_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++) begin
					prod_s1[a][i] <= $signed(axes[a][i]) * $signed(smooth[i]);
				end
			end
			for (int a = 0; a < 3; a++) begin
				proj[a] <= PROJ_W'(prod_s1[a][0]) + PROJ_W'(prod_s1[a][1])
					+ PROJ_W'(prod_s1[a][2]);
			end
		end
	end

endmodule

FILE: rtl/core/tangent_space_normal_bake.sv
// Pipeline: cross product, axis normalize, projection, color normalize, in that
//   order from vertex accept to color valid.
// Throughput: one vertex per cycle; the whole pipeline holds when the color
//   output is full and not taken.
// Reset: arst_n clears all stage valid bits; no vertex is in flight after reset.
// ----------------------------------------------------------------------------
// tangent_space_normal_bake
// Bitangent from N x T, unit T/B/N axes, smoothed normal projected into
// tangent space and normalized to a Q1.14 color.
// ----------------------------------------------------------------------------
module tangent_space_normal_bake
	import tsnb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vertex_valid,
	output logic    vertex_ready,
	input  vertex_t vertex,
	output logic    color_valid,
	input  logic    color_ready,
	output color_t  color
);

	localparam int PP_W = 2 * COMP_W;

	logic en;

	assign en           = !color_valid || color_ready;
	assign vertex_ready = en;

	// cross product products
	logic                   vld_s1;
	logic signed [PP_W-1:0] pp_s1 [6];
	logic [2:0][COMP_W-1:0] n_s1;
	logic [2:0][COMP_W-1:0] t_s1;
	logic [2:0][COMP_W-1:0] s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vertex_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= vertex.normal_y * vertex.tangent_z;
			pp_s1[1] <= vertex.normal_z * vertex.tangent_y;
			pp_s1[2] <= vertex.normal_z * vertex.tangent_x;
			pp_s1[3] <= vertex.normal_x * vertex.tangent_z;
			pp_s1[4] <= vertex.normal_x * vertex.tangent_y;
			pp_s1[5] <= vertex.normal_y * vertex.tangent_x;
			n_s1     <= {vertex.normal_z, vertex.normal_y, vertex.normal_x};
			t_s1     <= {vertex.tangent_z, vertex.tangent_y, vertex.tangent_x};
			s_s1     <= {vertex.smooth_z, vertex.smooth_y, vertex.smooth_x};
		end
	end

	// bitangent
	logic                    vld_s2;
	logic [2:0][CROSS_W-1:0] b_s2;
	logic [2:0][COMP_W-1:0]  n_s2;
	logic [2:0][COMP_W-1:0]  t_s2;
	logic [2:0][COMP_W-1:0]  s_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				b_s2[i] <= CROSS_W'(pp_s1[2*i]) - CROSS_W'(pp_s1[2*i+1]);
			end
			n_s2 <= n_s1;
			t_s2 <= t_s1;
			s_s2 <= s_s1;
		end
	end

	// axes
	logic                  t_valid, b_valid, n_valid;
	logic [2:0][OUT_W-1:0] t_unit, b_unit, n_unit;
	logic                  t_zero, b_zero, n_zero;

	tsnb_unitize #(.VW(COMP_W)) u_unit_t (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s2), .in_vec(t_s2),
		.out_valid(t_valid), .out_vec(t_unit), .out_zero(t_zero)
	);

	tsnb_unitize #(.VW(CROSS_W)) u_unit_b (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s2), .in_vec(b_s2),
		.out_valid(b_valid), .out_vec(b_unit), .out_zero(b_zero)
	);

	tsnb_unitize #(.VW(COMP_W)) u_unit_n (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(vld_s2), .in_vec(n_s2),
		.out_valid(n_valid), .out_vec(n_unit), .out_zero(n_zero)
	);

	// smoothed normal rides alongside the axis normalizers
	logic [2:0][COMP_W-1:0] smooth_s [UNIT_LAT+1];

	assign smooth_s[0] = s_s2;

	for (genvar k = 0; k < UNIT_LAT; k++) begin : g_smooth
		always_ff @(posedge clk) begin
			if (en) begin
				smooth_s[k+1] <= smooth_s[k];
			end
		end
	end

	// any degenerate axis clears all three, so the projection is zero and the
	// color comes out degenerate
	logic                  axes_ok;
	logic [2:0][OUT_W-1:0] t_axis, b_axis, n_axis;

	assign axes_ok = !(t_zero || b_zero || n_zero);
	assign t_axis  = axes_ok ? t_unit : '0;
	assign b_axis  = axes_ok ? b_unit : '0;
	assign n_axis  = axes_ok ? n_unit : '0;

	// projection
	logic                   p_valid;
	logic [2:0][PROJ_W-1:0] p_vec;

	tsnb_project u_project (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (t_valid),
		.axis_t   (t_axis),
		.axis_b   (b_axis),
		.axis_n   (n_axis),
		.smooth   (smooth_s[UNIT_LAT]),
		.out_valid(p_valid),
		.proj     (p_vec)
	);

	logic [2:0][OUT_W-1:0] c_unit;
	logic                  c_zero;

	tsnb_unitize #(.VW(PROJ_W)) u_unit_c (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(p_valid), .in_vec(p_vec),
		.out_valid(color_valid), .out_vec(c_unit), .out_zero(c_zero)
	);

	assign color.color_x    = c_unit[0];
	assign color.color_y    = c_unit[1];
	assign color.color_z    = c_unit[2];
	assign color.degenerate = c_zero;

	// axis normalizers run in lockstep
	a_axes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(t_valid == b_valid) && (t_valid == n_valid))
		else $error("axis normalizers out of step");

	// zero axis must give all-zero unit vector
	a_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		t_valid && (t_zero || b_zero || n_zero) |->
		((t_zero ? t_unit : (b_zero ? b_unit : n_unit)) == '0))
		else $error("degenerate axis not cleared");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && color.degenerate |->
		color.color_x == '0 && color.color_y == '0 && color.color_z == '0)
		else $error("degenerate color not zero");

	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid && !color.degenerate |->
		color.color_x != '0 || color.color_y != '0 || color.color_z != '0)
		else $error("unit color has no component");

	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		color_valid |->
		$signed(color.color_x) <= 16'sd16384 && $signed(color.color_x) >= -16'sd16384 &&
		$signed(color.color_y) <= 16'sd16384 && $signed(color.color_y) >= -16'sd16384 &&
		$signed(color.color_z) <= 16'sd16384 && $signed(color.color_z) >= -16'sd16384)
		else $error("color component beyond unit range");

endmodule
